FILE: src/euc_pkg.sv
// Shared types and constants for the event uniformity correction unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package euc_pkg;

	localparam int unsigned IMAGE_SIDE = 256;
	localparam int unsigned Q_BITS     = 31;
	localparam logic [31:0] RANDOM_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] WORD_MAX   = 32'h7FFF_FFFF;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_EVENT = 1'b1;

	localparam logic REG_MEAN   = 1'b0;
	localparam logic REG_ENABLE = 1'b1;

	typedef struct packed {
		logic        op;
		logic [7:0]  x;
		logic [7:0]  y;
		logic [31:0] flood_count;
		logic [30:0] random;
	} cmd_t;

	typedef struct packed {
		logic [7:0] event_x;
		logic [7:0] event_y;
		logic       final_copy;
	} result_t;

	// Item fields carried alongside the divider.
	typedef struct packed {
		logic        op;
		logic [7:0]  x;
		logic [7:0]  y;
		logic [30:0] random;
		logic        in_image;
	} tag_t;

endpackage
`default_nettype wire

FILE: src/euc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module euc_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 65536
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

FILE: src/euc_div.sv
// Pipelined restoring divider, one quotient bit per stage, with item tag.
// Depends on euc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module euc_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      en,
	input  wire logic                      in_valid,
	input  wire euc_pkg::tag_t             in_tag,
	input  wire logic [62:0]               in_num,
	input  wire logic [31:0]               in_den,
	input  wire logic                      in_sat,
	output logic                           out_valid,
	output euc_pkg::tag_t                  out_tag,
	output logic [euc_pkg::Q_BITS-1:0]     out_quo,
	output logic                           out_sat
);

	localparam int unsigned N = euc_pkg::Q_BITS;

	logic          vld_s [N+1];
	euc_pkg::tag_t tag_s [N+1];
	logic [31:0]   rem_s [N+1];
	logic [N-1:0]  low_s [N+1];
	logic [N-1:0]  quo_s [N+1];
	logic [31:0]   den_s [N+1];
	logic          sat_s [N+1];

	// Stage 0: the quotient fits Q_BITS, so the top bits start as the remainder.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s[0] <= in_tag;
			rem_s[0] <= in_num[62:N];
			low_s[0] <= in_num[N-1:0];
			quo_s[0] <= '0;
			den_s[0] <= in_den;
			sat_s[0] <= in_sat;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_stage
		logic [33:0] diff;
		logic        ge;

		always_comb begin
			diff = {1'b0, rem_s[i], low_s[i][N-1]} - {2'b00, den_s[i]};
			ge   = !diff[33];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				tag_s[i+1] <= tag_s[i];
				rem_s[i+1] <= ge ? diff[31:0] : {rem_s[i][30:0], low_s[i][N-1]};
				low_s[i+1] <= {low_s[i][N-2:0], 1'b0};
				quo_s[i+1] <= {quo_s[i][N-2:0], ge};
				den_s[i+1] <= den_s[i];
				sat_s[i+1] <= sat_s[i];
			end
		end
	end

	assign out_valid = vld_s[N];
	assign out_tag   = tag_s[N];
	assign out_quo   = quo_s[N];
	assign out_sat   = sat_s[N];

endmodule
`default_nettype wire

FILE: src/euc_out.sv
// Output stage: compare word with the random draw and sequence the copies.
// Depends on euc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module euc_out (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire euc_pkg::tag_t     in_tag,
	input  wire logic [31:0]       in_word,
	input  wire logic              enable,
	output logic                   stall,
	output logic                   result_valid,
	output euc_pkg::result_t       result
);

	logic        vld_s3;
	logic        two_s3;
	logic        drop_s3;
	logic [7:0]  x_s3;
	logic [7:0]  y_s3;
	logic        phase_q;
	logic [32:0] w_ext;
	logic [32:0] r_ext;
	logic [32:0] sum;
	logic        use_word;

	always_comb begin
		use_word = enable && in_tag.in_image;
		w_ext    = {in_word[31], in_word};
		r_ext    = {2'b00, in_tag.random};
		sum      = w_ext + r_ext;
	end

	assign stall = vld_s3 && two_s3 && !phase_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3  <= 1'b0;
			phase_q <= 1'b0;
		end else if (stall) begin
			phase_q <= 1'b1;
		end else begin
			vld_s3  <= in_valid;
			phase_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			two_s3  <= use_word && ($signed(r_ext) < $signed(w_ext));
			drop_s3 <= use_word && sum[32];
			x_s3    <= in_tag.x;
			y_s3    <= in_tag.y;
		end
	end

	always_comb begin
		result_valid      = vld_s3 && !drop_s3;
		result.event_x    = x_s3;
		result.event_y    = y_s3;
		result.final_copy = !two_s3 || phase_q;
	end

endmodule
`default_nettype wire

FILE: src/event_uniformity_correction_unit.sv
// Event uniformity correction unit: top level.
// Depends on euc_pkg, euc_div, euc_ram, euc_out.
// A result passes the divider stages, the table read and the output register.
// Throughput: one command per cycle while busy is low; an event that yields two
// copies raises busy for a single cycle while the first copy goes out.
// Reset clears the pipeline and registers; the correction table is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module event_uniformity_correction_unit #(
	parameter int unsigned IMAGE_SIDE = euc_pkg::IMAGE_SIDE
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire euc_pkg::cmd_t    cmd,
	output logic                  result_valid,
	output euc_pkg::result_t      result,
	input  wire logic             cfg_we,
	input  wire logic             cfg_index,
	input  wire logic [31:0]      cfg_data
);

	localparam int unsigned DEPTH = IMAGE_SIDE * IMAGE_SIDE;
	localparam int unsigned AW    = $clog2(DEPTH);

	logic [31:0] mean_q;
	logic        enable_q;

	// Configuration writes land at once; write them only while the block is idle (not enforced by the block).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mean_q   <= '0;
			enable_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				euc_pkg::REG_MEAN:   mean_q   <= cfg_data;
				euc_pkg::REG_ENABLE: enable_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	logic stall;
	logic adv;
	assign busy = stall;
	assign adv  = !stall;

	// Front end: RANDOM_MAX*mean is (mean << 31) - mean, no multiplier needed.
	logic [62:0]   num;
	logic          sat;
	euc_pkg::tag_t in_tag;

	always_comb begin
		num             = {mean_q, 31'b0} - {31'b0, mean_q};
		sat             = cmd.flood_count <= mean_q;
		in_tag.op       = cmd.op;
		in_tag.x        = cmd.x;
		in_tag.y        = cmd.y;
		in_tag.random   = cmd.random;
		in_tag.in_image = (32'(cmd.x) < 32'(IMAGE_SIDE)) && (32'(cmd.y) < 32'(IMAGE_SIDE));
	end

	// Every command walks the divider, so loads and events stay in order
	// when they reach the table.
	logic                       dv_valid;
	euc_pkg::tag_t              dv_tag;
	logic [euc_pkg::Q_BITS-1:0] dv_quo;
	logic                       dv_sat;

	euc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (start && !busy),
		.in_tag    (in_tag),
		.in_num    (num),
		.in_den    (cmd.flood_count),
		.in_sat    (sat),
		.out_valid (dv_valid),
		.out_tag   (dv_tag),
		.out_quo   (dv_quo),
		.out_sat   (dv_sat)
	);

	// Table access: loads write the word, events read it.
	logic [31:0] idx;
	logic [31:0] word;
	logic        tbl_we;
	logic        tbl_re;
	logic [31:0] rdata;

	always_comb begin
		idx    = 32'(dv_tag.y) * 32'(IMAGE_SIDE) + 32'(dv_tag.x);
		word   = dv_sat ? euc_pkg::WORD_MAX : ({1'b0, dv_quo} - euc_pkg::RANDOM_MAX);
		tbl_we = adv && dv_valid && dv_tag.in_image && (dv_tag.op == euc_pkg::OP_LOAD);
		tbl_re = adv && dv_valid && (dv_tag.op == euc_pkg::OP_EVENT);
	end

	euc_ram #(
		.WIDTH (32),
		.DEPTH (DEPTH)
	) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (idx[AW-1:0]),
		.wdata (word),
		.re    (tbl_re),
		.raddr (idx[AW-1:0]),
		.rdata (rdata)
	);

	// Hold the event beside the registered read data.
	logic          vld_s2;
	euc_pkg::tag_t tag_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= dv_valid && (dv_tag.op == euc_pkg::OP_EVENT);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s2 <= dv_tag;
		end
	end

	euc_out u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (vld_s2),
		.in_tag       (tag_s2),
		.in_word      (rdata),
		.enable       (enable_q),
		.stall        (stall),
		.result_valid (result_valid),
		.result       (result)
	);

	// Busy only while the first of two copies goes out.
	a_busy_first: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (result_valid && !result.final_copy))
		else $error("busy without a first copy on the output");

	// The second copy follows the first in the next cycle.
	a_second_copy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> (result_valid && result.final_copy && !busy))
		else $error("second copy missing after a first copy");

	// A non-final copy always holds the pipeline.
	a_first_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.final_copy) |-> busy)
		else $error("first copy emitted without holding the pipeline");

endmodule
`default_nettype wire
